FILE: design/bgcc_pkg.sv
// Shared types and constants for the binary grid cross center detector.
// Used by the line buffer and the top level; no dependencies.
package bgcc_pkg;

	typedef logic [1:0] code_t;

	localparam code_t CODE_CLEAR  = 2'd0;
	localparam code_t CODE_SET    = 2'd1;
	localparam code_t CODE_MARKED = 2'd2;

	// one line buffer entry holds the codes of both row parities of a column
	typedef struct packed {
		code_t odd;
		code_t even;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam int CFG_W    = 5;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int POS_OUT_W = 4;
	localparam int COUNT_W  = 9;
	localparam int SIZE_W   = 11;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
	localparam logic [CFG_W-1:0]   GRID_RESET = 5'd10;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

endpackage

FILE: design/bgcc_ram.sv
// Generic RAM with one write port and two registered read ports.
// Read-first on an address collision; no dependencies.
module bgcc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr0,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr1,
	output logic [WIDTH-1:0]                      rd_data0,
	output logic [WIDTH-1:0]                      rd_data1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data0 <= mem_q[rd_addr0];
		rd_data1 <= mem_q[rd_addr1];
	end

endmodule

FILE: design/bgcc_line.sv
// Two-row line buffer: one RAM entry per column, both row parities packed together.
// Prefetches a column and its right neighbor; forwards same-cycle writes.
// Depends on bgcc_pkg and bgcc_ram.
module bgcc_line
	import bgcc_pkg::*;
#(
	parameter int MAX_COLS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        wr_en,
	input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] wr_col,
	input  entry_t                                      wr_entry,
	input  logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] rd_col,
	output entry_t                                      cur_entry,
	output entry_t                                      nxt_entry
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLS - 1);

	logic [CW-1:0]      rd_col1;
	logic [ENTRY_W-1:0] ram_rd0;
	logic [ENTRY_W-1:0] ram_rd1;
	logic [MAX_COLS-1:0] written_q;
	logic               vld0_q;
	logic               vld1_q;
	logic               byp0_q;
	logic               byp1_q;
	entry_t             wd_q;

	assign rd_col1 = (rd_col == LAST_COL) ? '0 : rd_col + 1'b1;

	bgcc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_COLS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_col),
		.wr_data (wr_entry),
		.rd_addr0(rd_col),
		.rd_addr1(rd_col1),
		.rd_data0(ram_rd0),
		.rd_data1(ram_rd1)
	);

	// columns never written since reset read as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			vld0_q    <= 1'b0;
			vld1_q    <= 1'b0;
			byp0_q    <= 1'b0;
			byp1_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_col] <= 1'b1;
			end
			vld0_q <= written_q[rd_col];
			vld1_q <= written_q[rd_col1];
			byp0_q <= wr_en && (wr_col == rd_col);
			byp1_q <= wr_en && (wr_col == rd_col1);
		end
	end

	always_ff @(posedge clk) begin
		wd_q <= wr_entry;
	end

	always_comb begin
		cur_entry = vld0_q ? entry_t'(ram_rd0) : entry_t'('0);
		nxt_entry = vld1_q ? entry_t'(ram_rd1) : entry_t'('0);
		if (byp0_q) begin
			cur_entry = wd_q;
		end
		if (byp1_q) begin
			nxt_entry = wd_q;
		end
	end

endmodule

FILE: design/binary_grid_cross_center_detector_core.sv
// Binary grid cross center detector, top level.
// Latency: a result is valid in the cycle after its pixel is accepted (one output register).
// Throughput: one pixel per cycle while the output register is not stalled; the line buffer has a single write port.
// Reset: positions, count and line buffer valid bits clear; both size registers load 10.
// Line buffer contents need no clearing pass: unwritten columns read as clear.
// Depends on bgcc_pkg and bgcc_line.
module binary_grid_cross_center_detector_core
	import bgcc_pkg::*;
#(
	parameter int MAX_COLS = 16,
	parameter int MAX_ROWS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 decision_valid,
	output logic [POS_OUT_W-1:0] center_row,
	output logic [POS_OUT_W-1:0] center_col,
	output logic                 is_center,
	output logic [COUNT_W-1:0]   center_count,
	output logic                 frame_done
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [CFG_W-1:0]   grid_width_q;
	logic [CFG_W-1:0]   grid_height_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [COUNT_W-1:0] count_q;
	code_t              left_q;

	logic               cfg_wr;
	logic               accept;
	logic [SIZE_W-1:0]  gw_ext;
	logic [SIZE_W-1:0]  gh_ext;
	logic [SIZE_W-1:0]  w_eff;
	logic [SIZE_W-1:0]  h_eff;
	logic [SIZE_W-1:0]  col_ext;
	logic [SIZE_W-1:0]  row_ext;
	logic               last_col;
	logic               last_row;
	logic [CW-1:0]      col_nxt;
	logic [RW-1:0]      row_nxt;
	logic [CW-1:0]      rd_col;
	entry_t             cur_entry;
	entry_t             nxt_entry;
	entry_t             wr_entry;
	code_t              up_code;
	code_t              mid_code;
	code_t              right_code;
	code_t              px_code;
	code_t              mid_new;
	logic               have_prev;
	logic               center;
	logic [COUNT_W-1:0] count_nxt;
	logic [RW-1:0]      prev_row;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_RESET;
			grid_height_q <= GRID_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[CFG_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_q);
			REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_q);
			default:         prdata = '0;
		endcase
	end

	// handshake: the output register parts the two sides
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// clamp sizes to 1..max
	always_comb begin
		gw_ext = SIZE_W'(grid_width_q);
		gh_ext = SIZE_W'(grid_height_q);
		if (gw_ext == '0) begin
			w_eff = SIZE_W'(1);
		end else if (gw_ext > SIZE_W'(MAX_COLS)) begin
			w_eff = SIZE_W'(MAX_COLS);
		end else begin
			w_eff = gw_ext;
		end
		if (gh_ext == '0) begin
			h_eff = SIZE_W'(1);
		end else if (gh_ext > SIZE_W'(MAX_ROWS)) begin
			h_eff = SIZE_W'(MAX_ROWS);
		end else begin
			h_eff = gh_ext;
		end
	end

	assign col_ext  = SIZE_W'(col_q);
	assign row_ext  = SIZE_W'(row_q);
	assign last_col = (col_ext + SIZE_W'(1)) >= w_eff;
	assign last_row = (row_ext + SIZE_W'(1)) >= h_eff;
	assign col_nxt  = last_col ? '0 : col_q + 1'b1;
	assign row_nxt  = last_col ? (last_row ? '0 : row_q + 1'b1) : row_q;

	// prefetch the column the next pixel will need
	assign rd_col = accept ? col_nxt : col_q;

	bgcc_line #(
		.MAX_COLS(MAX_COLS)
	) u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr_col   (col_q),
		.wr_entry (wr_entry),
		.rd_col   (rd_col),
		.cur_entry(cur_entry),
		.nxt_entry(nxt_entry)
	);

	// decide cell (row-1, col); the row parity selects which half is the older row
	always_comb begin
		px_code    = pixel ? CODE_SET : CODE_CLEAR;
		up_code    = row_q[0] ? cur_entry.odd  : cur_entry.even;
		mid_code   = row_q[0] ? cur_entry.even : cur_entry.odd;
		right_code = row_q[0] ? nxt_entry.even : nxt_entry.odd;
		have_prev  = row_ext >= SIZE_W'(1);
		center     = (row_ext >= SIZE_W'(2)) && (col_ext >= SIZE_W'(1)) &&
			((col_ext + SIZE_W'(2)) <= w_eff) &&
			(mid_code == CODE_SET) && (up_code == CODE_SET) &&
			(left_q == CODE_SET) && (right_code == CODE_SET) && pixel;
		mid_new    = center ? CODE_MARKED : mid_code;
		if (row_q[0]) begin
			wr_entry.odd  = px_code;
			wr_entry.even = mid_new;
		end else begin
			wr_entry.even = px_code;
			wr_entry.odd  = mid_new;
		end
		count_nxt  = (center && (count_q != COUNT_MAX)) ? count_q + 1'b1 : count_q;
		prev_row   = row_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				col_q   <= col_nxt;
				row_q   <= row_nxt;
				count_q <= (last_col && last_row) ? '0 : count_nxt;
			end
			out_valid <= accept || (out_valid && out_stall);
		end
	end

	// hold the updated code of this column as the next left neighbor, and register the decision outputs
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q         <= mid_new;
			decision_valid <= have_prev;
			center_row     <= have_prev ? POS_OUT_W'(prev_row) : '0;
			center_col     <= have_prev ? POS_OUT_W'(col_q) : '0;
			is_center      <= center;
			center_count   <= count_nxt;
			frame_done     <= last_col && last_row;
		end
	end

endmodule

FILE: dv/binary_grid_cross_center_detector_core_tb.sv
// Self-checking testbench for binary_grid_cross_center_detector_core.
// Drives pixels and APB size writes, predicts each cell decision and checks it field by field.
// Depends on bgcc_pkg and the core RTL only.
`timescale 1ns / 1ps

module binary_grid_cross_center_detector_core_tb
	import bgcc_pkg::*;
();

	localparam int MAX_COLS    = 16;
	localparam int MAX_ROWS    = 16;
	localparam int HOLD_CYCLES = 120;
	localparam int NUM_PIXELS  = 750;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [ADDR_W-1:0] ADDR_GRID_WIDTH  = {REG_GRID_WIDTH, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_GRID_HEIGHT = {REG_GRID_HEIGHT, 2'b00};

	typedef struct packed {
		logic                 dvalid;
		logic [POS_OUT_W-1:0] row;
		logic [POS_OUT_W-1:0] col;
		logic                 center;
		logic [COUNT_W-1:0]   count;
		logic                 done;
	} decision_t;

	typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              px;
		bit                typed;
		decision_t         want;
	} stim_row_t;

	localparam int NUM_DIR = 33;

	// 3x3 all set: one center at (1,1); then 4x3 set but for its last pixel shows marking;
	// then size 0 (acts as 1x1) and size 31 (acts as 16x16)
	stim_row_t dir_rows [NUM_DIR] = '{
		'{ROW_CFG,   ADDR_GRID_WIDTH,  32'd3, 1'b0, 1'b0, '0},
		'{ROW_CFG,   ADDR_GRID_HEIGHT, 32'd3, 1'b0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd0, 4'd0, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd0, 4'd1, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd0, 4'd2, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd1, 4'd0, 1'b0, 9'd0, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd1, 4'd1, 1'b1, 9'd1, 1'b0}},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b1, 4'd1, 4'd2, 1'b0, 9'd1, 1'b1}},
		'{ROW_CFG,   ADDR_GRID_WIDTH,  32'd4, 1'b0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG,   ADDR_GRID_WIDTH,  32'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG,   ADDR_GRID_HEIGHT, 32'd0, 1'b0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 9'd0, 1'b1}},
		'{ROW_PIXEL, '0, '0, 1'b0, 1'b1, '{1'b0, 4'd0, 4'd0, 1'b0, 9'd0, 1'b1}},
		'{ROW_CFG,   ADDR_GRID_WIDTH,  32'd31, 1'b0, 1'b0, '0},
		'{ROW_CFG,   ADDR_GRID_HEIGHT, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b0, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0},
		'{ROW_PIXEL, '0, '0, 1'b1, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 pixel = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 decision_valid;
	logic [POS_OUT_W-1:0] center_row;
	logic [POS_OUT_W-1:0] center_col;
	logic                 is_center;
	logic [COUNT_W-1:0]   center_count;
	logic                 frame_done;

	// payload side info that travels with the offered pixel
	bit        cur_typed = 1'b0;
	decision_t cur_want = '0;

	// predictor state
	code_t            cell_codes [2*MAX_COLS] = '{default: CODE_CLEAR};
	int unsigned      row_pos = 0;
	int unsigned      col_pos = 0;
	int unsigned      found_cnt = 0;
	logic [CFG_W-1:0] width_reg = GRID_RESET;
	logic [CFG_W-1:0] height_reg = GRID_RESET;

	decision_t   pending_decisions [$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          hold_req = 1'b0;

	binary_grid_cross_center_detector_core #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned slot_of(int unsigned r, int unsigned c);
		return (r & 1) * MAX_COLS + c;
	endfunction

	function automatic decision_t decide_cell(logic px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned pr;
		decision_t d;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
		h = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);
		r = row_pos;
		c = col_pos;
		d = '0;
		if (r >= 1) begin
			pr = r - 1;
			d.dvalid = 1'b1;
			d.row = POS_OUT_W'(pr);
			d.col = POS_OUT_W'(c);
			if (pr >= 1 && c >= 1 && c + 2 <= w && px &&
			    cell_codes[slot_of(pr, c)] == CODE_SET &&
			    cell_codes[slot_of(r, c)] == CODE_SET &&
			    cell_codes[slot_of(pr, c - 1)] == CODE_SET &&
			    cell_codes[slot_of(pr, c + 1)] == CODE_SET) begin
				d.center = 1'b1;
				cell_codes[slot_of(pr, c)] = CODE_MARKED;
				if (found_cnt < COUNT_MAX)
					found_cnt++;
			end
		end
		// the slot of row r-2 is free now; it takes row r
		cell_codes[slot_of(r, c)] = px ? CODE_SET : CODE_CLEAR;
		d.count = COUNT_W'(found_cnt);
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				d.done = 1'b1;
				row_pos = 0;
				found_cnt = 0;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
		return d;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	// mostly back to back, some short gaps, rare long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_decisions.size() == 0) begin
					report_mismatch("result transaction with nothing pending");
				end else begin
					decision_t want;
					want = pending_decisions.pop_front();
					check_field("decision_valid", decision_valid, want.dvalid);
					check_field("center_row", center_row, want.row);
					check_field("center_col", center_col, want.col);
					check_field("is_center", is_center, want.center);
					check_field("center_count", center_count, want.count);
					check_field("frame_done", frame_done, want.done);
				end
			end
			if (in_valid && !in_stall) begin
				decision_t pred;
				pred = decide_cell(pixel);
				pending_decisions.push_back(cur_typed ? cur_want : pred);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: random stall runs, quiet stretches, and one long hold on request
	initial begin
		int unsigned stall_left;
		int unsigned hold_cnt;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_quiet) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else begin
				if (stall_left == 0 && $urandom_range(0, 99) < 25)
					stall_left = pick_gap() + 1;
				if (stall_left > 0) begin
					out_stall <= 1'b1;
					stall_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic offer_pixel(logic px, bit typed, decision_t want);
		int unsigned gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// keep valid high across back to back transactions
		in_valid <= 1'b1;
		pixel <= px;
		cur_typed <= typed;
		cur_want <= want;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[ADDR_W-1:2] == REG_GRID_WIDTH)
			width_reg = data[CFG_W-1:0];
		else if (addr[ADDR_W-1:2] == REG_GRID_HEIGHT)
			height_reg = data[CFG_W-1:0];
	endtask

	initial begin
		int unsigned sent;
		int unsigned phase;
		int unsigned sel;
		int unsigned ew;
		int unsigned eh;
		int unsigned n;
		int unsigned density;
		logic [CFG_W-1:0] w_val;
		logic [CFG_W-1:0] h_val;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				drain_results();
				apb_write(dir_rows[i].addr, dir_rows[i].data);
			end else begin
				offer_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		sent = 0;
		phase = 0;
		while (sent < NUM_PIXELS) begin
			drain_results();
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				w_val = CFG_W'($urandom_range(3, 6));
				h_val = CFG_W'($urandom_range(3, 6));
			end else if (sel < 8) begin
				w_val = CFG_W'($urandom_range(0, 31));
				h_val = CFG_W'($urandom_range(0, 31));
			end else if (sel == 8) begin
				w_val = $urandom_range(0, 1) ? 5'd31 : 5'd16;
				h_val = $urandom_range(0, 1) ? 5'd0 : 5'd1;
			end else begin
				w_val = CFG_W'($urandom_range(1, 2));
				h_val = CFG_W'($urandom_range(16, 31));
			end
			// each register is usually rewritten, which can also change size mid-frame
			if ($urandom_range(0, 3) != 0)
				apb_write(ADDR_GRID_WIDTH, DATA_W'({$urandom(), w_val}));
			if ($urandom_range(0, 3) != 0)
				apb_write(ADDR_GRID_HEIGHT, DATA_W'({$urandom(), h_val}));

			ew = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
			eh = (height_reg == 0) ? 1 : ((height_reg > MAX_ROWS) ? MAX_ROWS : height_reg);
			n = ew * eh * $urandom_range(1, 2);
			if (n > 160)
				n = 160;
			if (n < 8)
				n = 8;
			if (n > NUM_PIXELS - sent)
				n = NUM_PIXELS - sent;
			density = ($urandom_range(0, 4) == 0) ? 50 : 88;
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// hold the output so the core fills and stalls the pixel stream
				tx_quiet = 1'b1;
				hold_req = 1'b1;
			end
			repeat (n)
				offer_pixel($urandom_range(0, 99) < density, 1'b0, '0);
			sent += n;
			phase++;
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: sim.f
design/bgcc_pkg.sv
design/bgcc_ram.sv
design/bgcc_line.sv
design/binary_grid_cross_center_detector_core.sv
dv/binary_grid_cross_center_detector_core_tb.sv
